FILE: rtl/array_insert_delete_engine_assert.svh
// Assertion macros for the array insert/delete engine.
`ifndef ARRAY_INSERT_DELETE_ENGINE_ASSERT_SVH
`define ARRAY_INSERT_DELETE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define AIDE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define AIDE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AIDE_ASSERT(lbl, prop, msg)
`define AIDE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/aide_pkg.sv
// Types and constants shared by the array insert/delete engine.
package aide_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int WORD_BITS_DEF = 32;
	localparam int LEN_W         = 7;
	localparam int FIELD_W       = 32;

	typedef enum logic [3:0] {
		OP_APPEND           = 4'd0,
		OP_PREPEND          = 4'd1,
		OP_INSERT_AT        = 4'd2,
		OP_DROP_END         = 4'd3,
		OP_DROP_FRONT       = 4'd4,
		OP_DELETE_AT        = 4'd5,
		OP_INSERT_AFTER_KEY = 4'd6,
		OP_DELETE_KEY       = 4'd7,
		OP_READ_AT          = 4'd8
	} aide_op_t;

	typedef enum logic [1:0] {
		STS_DONE   = 2'd0,
		STS_REJECT = 2'd1,
		STS_FULL   = 2'd2
	} aide_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_COPY,
		S_PLACE,
		S_READ
	} aide_state_t;

	typedef struct packed {
		logic [3:0]                operation;
		logic [5:0]                position;
		logic [6:0]                amount;
		logic signed [FIELD_W-1:0] value;
		logic signed [FIELD_W-1:0] key;
	} aide_in_t;

	typedef struct packed {
		logic [1:0]                status;
		logic [LEN_W-1:0]          length;
		logic signed [FIELD_W-1:0] read_word;
	} aide_out_t;

endpackage

FILE: rtl/aide_ram.sv
// Element store: one write port, one read port with registered read data.
module aide_ram #(
	parameter int DEPTH     = aide_pkg::DEPTH_DEF,
	parameter int WORD_BITS = aide_pkg::WORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(DEPTH)-1:0]     waddr,
	input  logic [WORD_BITS-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0]     raddr,
	output logic [WORD_BITS-1:0]         rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/array_insert_delete_engine.sv
// Array insert/delete engine top level: sequencer around one element RAM.
//
//  channel | signals            | handshake
//  --------+--------------------+------------------------------------------
//  command | start, busy, cmd   | beat taken on a clock edge with start & !busy
//  result  | done, result       | one beat per command, done high one cycle
//
// Timing: drop_end and commands refused on their arguments at the beat answer
// the cycle after it; read_at waits for the registered RAM read; shifting
// commands, append among them, run a copy pass over the moved elements; insert_after_key
// adds a key scan over the stored elements before that, and a miss ends there.
// One element moves per cycle over the RAM port pair. Reset clears the length;
// the store needs no clearing. The result side cannot stall.
`include "array_insert_delete_engine_assert.svh"

module array_insert_delete_engine #(
	parameter int DEPTH     = aide_pkg::DEPTH_DEF,
	parameter int WORD_BITS = aide_pkg::WORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  aide_pkg::aide_in_t  cmd,
	output logic                done,
	output aide_pkg::aide_out_t result
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 7) ? CW : 7;
	localparam int EXW  = (WORD_BITS > aide_pkg::FIELD_W) ? WORD_BITS : aide_pkg::FIELD_W;

	aide_pkg::aide_state_t  state_q, state_d;
	aide_pkg::aide_status_t status_q, status_d;

	logic [CW-1:0]        count_q, count_d;
	logic                 done_q, done_d;
	logic [AW-1:0]        rd_ptr_q, rd_ptr_d;
	logic [CW-1:0]        wr_ptr_q, wr_ptr_d;
	logic [CW-1:0]        rem_q, rem_d;
	logic                 pend_q, pend_d;
	logic [AW-1:0]        at_q, at_d;
	logic [CW-1:0]        new_cnt_q, new_cnt_d;
	logic                 up_q, up_d;
	logic                 compact_q, compact_d;
	logic                 place_q, place_d;
	logic [WORD_BITS-1:0] val_q, val_d;
	logic [WORD_BITS-1:0] key_q, key_d;
	logic [aide_pkg::FIELD_W-1:0] rword_q, rword_d;

	// RAM port
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [WORD_BITS-1:0] wdata;
	logic [AW-1:0]        raddr;
	logic [WORD_BITS-1:0] rdata;

	// setup of the shift-up (insert) and shift-down (remove) passes
	logic                 ins_go;
	logic [CW-1:0]        ins_at;
	logic                 cp_go;
	logic [CW-1:0]        cp_rd;
	logic [CW-1:0]        cp_wr;
	logic [CW-1:0]        cp_n;
	logic [CW-1:0]        cp_new;
	logic                 cp_compact;

	logic [CMPW-1:0]      cnt_x, pos_x, amt_x;
	logic [CW-1:0]        cnt_m1;
	logic                 full;
	logic [EXW-1:0]       val_ext, key_ext, rd_ext;

	assign cnt_x   = CMPW'(count_q);
	assign pos_x   = CMPW'(cmd.position);
	assign amt_x   = CMPW'(cmd.amount);
	assign cnt_m1  = count_q - CW'(1);
	assign full    = (count_q == CW'(DEPTH));
	assign val_ext = EXW'(cmd.value);
	assign key_ext = EXW'(cmd.key);
	assign rd_ext  = EXW'(signed'(rdata));

	aide_ram #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d    = state_q;
		status_d   = status_q;
		count_d    = count_q;
		done_d     = 1'b0;
		rd_ptr_d   = rd_ptr_q;
		wr_ptr_d   = wr_ptr_q;
		rem_d      = rem_q;
		pend_d     = pend_q;
		at_d       = at_q;
		new_cnt_d  = new_cnt_q;
		up_d       = up_q;
		compact_d  = compact_q;
		place_d    = place_q;
		val_d      = val_q;
		key_d      = key_q;
		rword_d    = rword_q;
		we         = 1'b0;
		waddr      = wr_ptr_q[AW-1:0];
		wdata      = rdata;
		raddr      = rd_ptr_q;
		ins_go     = 1'b0;
		ins_at     = '0;
		cp_go      = 1'b0;
		cp_rd      = '0;
		cp_wr      = '0;
		cp_n       = '0;
		cp_new     = '0;
		cp_compact = 1'b0;

		case (state_q)
			aide_pkg::S_IDLE: begin
				if (start) begin
					val_d   = val_ext[WORD_BITS-1:0];
					key_d   = key_ext[WORD_BITS-1:0];
					rword_d = '0;
					case (aide_pkg::aide_op_t'(cmd.operation))
						aide_pkg::OP_APPEND: begin
							if (full) begin
								status_d = aide_pkg::STS_FULL;
								done_d   = 1'b1;
							end else begin
								ins_go = 1'b1;
								ins_at = count_q;
							end
						end
						aide_pkg::OP_PREPEND: begin
							if (full) begin
								status_d = aide_pkg::STS_FULL;
								done_d   = 1'b1;
							end else begin
								ins_go = 1'b1;
								ins_at = '0;
							end
						end
						aide_pkg::OP_INSERT_AT: begin
							if (pos_x >= cnt_x) begin
								status_d = aide_pkg::STS_REJECT;
								done_d   = 1'b1;
							end else if (full) begin
								status_d = aide_pkg::STS_FULL;
								done_d   = 1'b1;
							end else begin
								ins_go = 1'b1;
								ins_at = CW'(cmd.position);
							end
						end
						aide_pkg::OP_DROP_END: begin
							done_d = 1'b1;
							if (amt_x > cnt_x) begin
								status_d = aide_pkg::STS_REJECT;
							end else begin
								status_d = aide_pkg::STS_DONE;
								count_d  = CW'(cnt_x - amt_x);
							end
						end
						aide_pkg::OP_DROP_FRONT: begin
							if (amt_x > cnt_x) begin
								status_d = aide_pkg::STS_REJECT;
								done_d   = 1'b1;
							end else begin
								cp_go  = 1'b1;
								cp_rd  = CW'(amt_x);
								cp_wr  = '0;
								cp_n   = CW'(cnt_x - amt_x);
								cp_new = CW'(cnt_x - amt_x);
							end
						end
						aide_pkg::OP_DELETE_AT: begin
							if (pos_x >= cnt_x) begin
								status_d = aide_pkg::STS_REJECT;
								done_d   = 1'b1;
							end else begin
								cp_go  = 1'b1;
								cp_rd  = CW'(pos_x + CMPW'(1));
								cp_wr  = CW'(pos_x);
								cp_n   = CW'(cnt_x - pos_x - CMPW'(1));
								cp_new = cnt_m1;
							end
						end
						aide_pkg::OP_INSERT_AFTER_KEY: begin
							rd_ptr_d = '0;
							wr_ptr_d = '0;
							rem_d    = count_q;
							pend_d   = 1'b0;
							state_d  = aide_pkg::S_SEARCH;
						end
						aide_pkg::OP_DELETE_KEY: begin
							cp_go      = 1'b1;
							cp_compact = 1'b1;
							cp_n       = count_q;
						end
						aide_pkg::OP_READ_AT: begin
							if (pos_x >= cnt_x) begin
								status_d = aide_pkg::STS_REJECT;
								done_d   = 1'b1;
							end else begin
								raddr   = AW'(cmd.position);
								state_d = aide_pkg::S_READ;
							end
						end
						default: begin
							status_d = aide_pkg::STS_REJECT;
							done_d   = 1'b1;
						end
					endcase
				end
			end

			aide_pkg::S_SEARCH: begin
				// wr_ptr_q holds the index of the word now in rdata
				if (pend_q && rdata == key_q) begin
					if (full) begin
						status_d = aide_pkg::STS_FULL;
						done_d   = 1'b1;
						state_d  = aide_pkg::S_IDLE;
					end else begin
						ins_go = 1'b1;
						ins_at = wr_ptr_q + CW'(1);
					end
				end else if (!pend_q && rem_q == '0) begin
					status_d = aide_pkg::STS_REJECT;
					done_d   = 1'b1;
					state_d  = aide_pkg::S_IDLE;
				end else begin
					if (pend_q) begin
						wr_ptr_d = wr_ptr_q + CW'(1);
					end
					if (rem_q != '0) begin
						rd_ptr_d = rd_ptr_q + AW'(1);
						rem_d    = rem_q - CW'(1);
						pend_d   = 1'b1;
					end else begin
						pend_d = 1'b0;
					end
				end
			end

			aide_pkg::S_COPY: begin
				// read leads, and the write trails it through the registered RAM read data
				if (pend_q && (!compact_q || rdata != key_q)) begin
					we       = 1'b1;
					wr_ptr_d = up_q ? (wr_ptr_q - CW'(1)) : (wr_ptr_q + CW'(1));
				end
				if (rem_q != '0) begin
					rd_ptr_d = up_q ? (rd_ptr_q - AW'(1)) : (rd_ptr_q + AW'(1));
					rem_d    = rem_q - CW'(1);
					pend_d   = 1'b1;
				end else begin
					pend_d = 1'b0;
				end
				if (!pend_q && rem_q == '0) begin
					if (place_q) begin
						state_d = aide_pkg::S_PLACE;
					end else begin
						done_d  = 1'b1;
						state_d = aide_pkg::S_IDLE;
						if (compact_q) begin
							if (wr_ptr_q == count_q) begin
								status_d = aide_pkg::STS_REJECT;
							end else begin
								status_d = aide_pkg::STS_DONE;
								count_d  = wr_ptr_q;
							end
						end else begin
							status_d = aide_pkg::STS_DONE;
							count_d  = new_cnt_q;
						end
					end
				end
			end

			aide_pkg::S_PLACE: begin
				we       = 1'b1;
				waddr    = at_q;
				wdata    = val_q;
				count_d  = count_q + CW'(1);
				status_d = aide_pkg::STS_DONE;
				done_d   = 1'b1;
				state_d  = aide_pkg::S_IDLE;
			end

			aide_pkg::S_READ: begin
				rword_d  = rd_ext[aide_pkg::FIELD_W-1:0];
				status_d = aide_pkg::STS_DONE;
				done_d   = 1'b1;
				state_d  = aide_pkg::S_IDLE;
			end

			default: begin
				state_d = aide_pkg::S_IDLE;
			end
		endcase

		if (ins_go) begin
			at_d      = ins_at[AW-1:0];
			rem_d     = count_q - ins_at;
			rd_ptr_d  = cnt_m1[AW-1:0];
			wr_ptr_d  = count_q;
			pend_d    = 1'b0;
			up_d      = 1'b1;
			compact_d = 1'b0;
			place_d   = 1'b1;
			state_d   = aide_pkg::S_COPY;
		end
		if (cp_go) begin
			rd_ptr_d  = cp_rd[AW-1:0];
			wr_ptr_d  = cp_wr;
			rem_d     = cp_n;
			new_cnt_d = cp_new;
			pend_d    = 1'b0;
			up_d      = 1'b0;
			compact_d = cp_compact;
			place_d   = 1'b0;
			state_d   = aide_pkg::S_COPY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= aide_pkg::S_IDLE;
			status_q <= aide_pkg::STS_DONE;
			count_q  <= '0;
			done_q   <= 1'b0;
			pend_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			count_q  <= count_d;
			done_q   <= done_d;
			pend_q   <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_ptr_q  <= rd_ptr_d;
		wr_ptr_q  <= wr_ptr_d;
		rem_q     <= rem_d;
		at_q      <= at_d;
		new_cnt_q <= new_cnt_d;
		up_q      <= up_d;
		compact_q <= compact_d;
		place_q   <= place_d;
		val_q     <= val_d;
		key_q     <= key_d;
		rword_q   <= rword_d;
	end

	assign busy             = (state_q != aide_pkg::S_IDLE);
	assign done             = done_q;
	assign result.status    = status_q;
	assign result.length    = aide_pkg::LEN_W'(count_q);
	assign result.read_word = rword_q;

	`AIDE_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "length beyond store depth")
	`AIDE_ASSERT(a_full_only_when_full, (done_q && status_q == aide_pkg::STS_FULL) |-> full, "full status with room left")
	`AIDE_ASSERT(a_accept_progress, (start && !busy) |=> (busy || done), "command beat neither started nor answered")

endmodule
